FILE: rtl/binary_to_decimal_ascii_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define B2DA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define B2DA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/b2da_pkg.sv
`default_nettype none
package b2da_pkg;

  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int BcdWidth   = 4 * NumDigits;
  localparam int CharWidth  = 6;
  localparam int BitCntWidth = $clog2(ValueWidth);
  localparam int PosWidth   = $clog2(NumDigits);

  localparam logic [CharWidth-1:0]   AsciiZero = 6'd48;
  localparam logic [BitCntWidth-1:0] LastBit   = BitCntWidth'(ValueWidth - 1);
  localparam logic [PosWidth-1:0]    LastPos   = PosWidth'(NumDigits - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic last_pos;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/b2da_datapath.sv
`default_nettype none
module b2da_datapath import b2da_pkg::*; (
  input  wire logic                  clk,
  input  wire logic [ValueWidth-1:0] value,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic [CharWidth-1:0]       digit_char
);

  logic [ValueWidth-1:0]  bin;
  logic [BcdWidth-1:0]    bcd;
  logic [BcdWidth-1:0]    bcd_adj;
  logic [BitCntWidth-1:0] bit_cnt;
  logic [PosWidth-1:0]    pos;
  logic [3:0]             top_digit;

  // Each BCD digit of 5 or more gets 3 added before the shift, so it carries
  // correctly into the next digit.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= value;
      bcd     <= '0;
      bit_cnt <= '0;
      pos     <= '0;
    end else if (cmd.dabble) begin
      bin     <= {bin[ValueWidth-2:0], 1'b0};
      bcd     <= {bcd_adj[BcdWidth-2:0], bin[ValueWidth-1]};
      bit_cnt <= bit_cnt + 1'b1;
    end else if (cmd.shift_digit) begin
      bcd <= {bcd[BcdWidth-5:0], 4'd0};
      pos <= pos + 1'b1;
    end
  end

  assign top_digit = bcd[BcdWidth-1 -: 4];

  assign status.conv_done = (bit_cnt == LastBit);
  assign status.top_zero  = (top_digit == 4'd0);
  assign status.last_pos  = (pos == LastPos);

  assign digit_char = AsciiZero + {2'b00, top_digit};

endmodule
`default_nettype wire

FILE: rtl/b2da_ctrl.sv
`default_nettype none
module b2da_ctrl import b2da_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         digit_strobe,
  output logic         last_digit
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next      = state;
    cmd.load        = 1'b0;
    cmd.dabble      = 1'b0;
    cmd.shift_digit = 1'b0;
    unique case (state)
      StIdle: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = StConv;
        end
      end
      StConv: begin
        cmd.dabble = 1'b1;
        if (status.conv_done) begin
          state_next = StSkip;
        end
      end
      StSkip: begin
        // The units digit is never skipped, so zero still yields one digit.
        if (status.top_zero && !status.last_pos) begin
          cmd.shift_digit = 1'b1;
        end else begin
          state_next = StEmit;
        end
      end
      StEmit: begin
        cmd.shift_digit = 1'b1;
        if (status.last_pos) begin
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  assign busy         = (state != StIdle);
  assign digit_strobe = (state == StEmit);
  assign last_digit   = (state == StEmit) && status.last_pos;

endmodule
`default_nettype wire

FILE: rtl/binary_to_decimal_ascii.sv
`default_nettype none
// Binary to decimal ASCII converter for one unsigned 32-bit value.
//
// Request channel: drive value and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// last digit has been presented.
// Result channel: each decimal digit appears on digit_char (ASCII '0' to '9')
// for exactly one cycle with digit_strobe high, most significant digit first,
// leading zeros suppressed; last_digit marks the units digit. Zero gives a
// single '0'. The receiver cannot stall the block.
// Sequence: a shift-and-add-3 conversion takes in the value one bit at a time,
// most significant bit first. Leading zero digits are then dropped one by one,
// the controller turns to output, and the n digits follow on consecutive
// cycles. busy is therefore high for equally long per request whatever the
// value, and the first digit shows later for values with fewer digits. A new
// request is not taken until busy has dropped.
// Reset: rst is synchronous; it returns the controller to idle and drops any
// conversion in flight. No state carries from one value to the next.
module binary_to_decimal_ascii import b2da_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [ValueWidth-1:0] value,
  output logic                       busy,
  output logic                       digit_strobe,
  output logic [CharWidth-1:0]       digit_char,
  output logic                       last_digit
);

  cmd_t    cmd;
  status_t status;

  b2da_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .digit_strobe (digit_strobe),
    .last_digit   (last_digit)
  );

  b2da_datapath u_datapath (
    .clk        (clk),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digit_char)
  );

endmodule
`default_nettype wire

FILE: rtl/b2da_checker.sv
`default_nettype none
`include "binary_to_decimal_ascii_assert.svh"
module b2da_checker import b2da_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 digit_strobe,
  input wire logic [CharWidth-1:0] digit_char,
  input wire logic                 last_digit
);

  logic char_ok;
  logic run_end;
  assign char_ok = (digit_char >= AsciiZero) && (digit_char <= AsciiZero + 6'd9);
  assign run_end = digit_strobe && last_digit;

  `B2DA_ASSERT_SAME(a_strobe_busy, clk, rst, digit_strobe, busy, "digit while not busy")
  `B2DA_ASSERT_SAME(a_char_range, clk, rst, digit_strobe, char_ok, "digit out of range")
  `B2DA_ASSERT_NEXT(a_request_busy, clk, rst, start && !busy, busy, "request left busy low")
  `B2DA_ASSERT_NEXT(a_last_ends, clk, rst, run_end, !digit_strobe && !busy, "digit after last")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .digit_strobe (digit_strobe),
  .digit_char   (digit_char),
  .last_digit   (last_digit)
);
`default_nettype wire
